/* src/rowol_pkg.sv */
`timescale 1ns / 1ps
// Package for the ring of writes with offset lookup: port field widths and
// default sizes. No dependencies.
package rowol_pkg;

  // Fixed widths of the stream fields
  localparam int MODE_W     = 1;
  localparam int HANDLE_W   = 32;
  localparam int SIZE_W     = 16;
  localparam int OFFSET_W   = 20;
  localparam int SLOT_IDX_W = 4;
  localparam int BYTE_OFS_W = 16;

  // Packed stream widths, padded to whole bytes
  localparam int IN_TDATA_W  = 72;  // handle 32 + size 16 + offset 20 = 68
  localparam int OUT_TDATA_W = 56;  // slot 4 + handle 32 + byte offset 16 = 52

  // Default sizes of the ring
  localparam int DEF_SLOTS       = 10;
  localparam int DEF_SIZE_BITS   = 16;
  localparam int DEF_HANDLE_BITS = 32;

  // Item kinds carried on in_tuser
  localparam logic [MODE_W-1:0] MODE_ADD  = 1'b0;
  localparam logic [MODE_W-1:0] MODE_FIND = 1'b1;

endpackage

/* src/rowol_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module rowol_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* src/ring_of_writes_with_offset_lookup.sv */
`timescale 1ns / 1ps
// Ring of SLOTS (handle, length) entries with a character-offset lookup.
// An add transfer writes its entry to the entry RAM and gives no result; a find
//   walks the ring one slot per cycle through the entry RAM read port and
//   holds in_tready low until its result enters the output register.
// Throughput: one add per cycle while no find walk is running.
// Reset (rst_n, synchronous, active low) clears the slot pointers, the full flag
//   and the per-slot valid bits, so every slot reads as handle 0, length 0.
module ring_of_writes_with_offset_lookup
  import rowol_pkg::*;
#(
  parameter int SLOTS       = DEF_SLOTS,
  parameter int SIZE_BITS   = DEF_SIZE_BITS,
  parameter int HANDLE_BITS = DEF_HANDLE_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input channel
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [31:0] entry_handle, [47:32] entry_size,
                                             // [67:48] char_pos, [71:68] zero
  input  logic [MODE_W-1:0]      in_tuser,   // [0] mode
  // Result channel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [3:0] slot_index, [35:4] found_handle,
                                             // [51:36] byte_offset, [55:52] zero
  output logic                   out_tuser   // [0] found
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int RAM_W  = HANDLE_BITS + SIZE_BITS;
  // Running total never exceeds SLOTS * 2^SIZE_BITS
  localparam int TOT_W  = SIZE_BITS + SLOT_W + 1;
  localparam int CMP_W  = (TOT_W > OFFSET_W) ? TOT_W : OFFSET_W;

  // ---------------------------------------------------------------------------
  // Input unpack
  // ---------------------------------------------------------------------------
  logic                in_xfer;
  logic [HANDLE_W-1:0] in_handle;
  logic [SIZE_W-1:0]   in_size;
  logic [OFFSET_W-1:0] in_offset;

  assign in_xfer   = in_tvalid & in_tready;
  assign in_handle = in_tdata[HANDLE_W-1:0];
  assign in_size   = in_tdata[HANDLE_W+SIZE_W-1:HANDLE_W];
  assign in_offset = in_tdata[HANDLE_W+SIZE_W+OFFSET_W-1:HANDLE_W+SIZE_W];

  // ---------------------------------------------------------------------------
  // Ring pointers and per-slot valid bits
  // ---------------------------------------------------------------------------
  logic [SLOT_W-1:0] wslot_r, wslot_nxt;
  logic [SLOT_W-1:0] rslot_r, rslot_nxt;
  logic              full_r, full_nxt;
  logic [SLOTS-1:0]  vld_r, vld_nxt;
  logic              add_xfer, find_xfer;
  logic [SLOT_W-1:0] wslot_inc;

  assign add_xfer  = in_xfer && (in_tuser == MODE_ADD);
  assign find_xfer = in_xfer && (in_tuser == MODE_FIND);
  assign wslot_inc = (wslot_r == SLOT_W'(SLOTS - 1)) ? '0 : wslot_r + 1'b1;

  always_comb begin
    wslot_nxt = wslot_r;
    rslot_nxt = rslot_r;
    full_nxt  = full_r;
    vld_nxt   = vld_r;
    if (add_xfer) begin
      vld_nxt[wslot_r] = 1'b1;
      wslot_nxt        = wslot_inc;
      // Once the write slot catches the read slot, drag the read slot along
      if (wslot_inc == rslot_r || full_r) begin
        full_nxt  = 1'b1;
        rslot_nxt = wslot_inc;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Entry RAM: {handle, length} per slot
  // ---------------------------------------------------------------------------
  logic              rd_en;
  logic [SLOT_W-1:0] rd_addr;
  logic [RAM_W-1:0]  rd_data;
  logic [RAM_W-1:0]  wr_data;

  assign wr_data = {HANDLE_BITS'(in_handle), SIZE_BITS'(in_size)};

  rowol_ram #(
    .WIDTH (RAM_W),
    .DEPTH (SLOTS)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (add_xfer),
    .wr_addr (wslot_r),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // ---------------------------------------------------------------------------
  // Find walk: issue one slot read per cycle, evaluate the returned entry
  // the cycle after against the running total.
  // ---------------------------------------------------------------------------
  logic              walking_r, walking_nxt;
  logic [SLOT_W-1:0] issue_idx_r, issue_idx_nxt;
  logic [CNT_W-1:0]  issue_cnt_r, issue_cnt_nxt;
  logic              pend_r, pend_nxt;
  logic              pend_last_r, pend_last_nxt;
  logic              pend_vld_r, pend_vld_nxt;
  logic [SLOT_W-1:0] pend_idx_r, pend_idx_nxt;
  logic [CMP_W-1:0]  before_r, before_nxt;
  logic [OFFSET_W-1:0] offset_r, offset_nxt;

  logic [HANDLE_BITS-1:0] ent_handle;
  logic [SIZE_BITS-1:0]   ent_size;
  logic [CMP_W-1:0]       ent_end;
  logic [CMP_W-1:0]       ofs_wide;
  logic [CMP_W-1:0]       ofs_rel;
  logic                   hit, done, stall, issue;
  logic [SLOT_W-1:0]      issue_inc;

  // Slots never written since reset read as handle 0, length 0
  assign ent_handle = pend_vld_r ? rd_data[RAM_W-1:SIZE_BITS] : '0;
  assign ent_size   = pend_vld_r ? rd_data[SIZE_BITS-1:0] : '0;
  assign ent_end    = before_r + CMP_W'(ent_size);
  assign ofs_wide   = CMP_W'(offset_r);
  assign ofs_rel    = ofs_wide - before_r;

  assign hit   = pend_r && (ofs_wide < ent_end) && (ofs_wide >= before_r);
  assign done  = hit || (pend_r && pend_last_r);
  // Hold the walk while a finished result cannot enter the output register
  assign stall = done && out_tvalid && !out_tready;
  assign issue = walking_r && !done && (issue_cnt_r != CNT_W'(SLOTS));

  assign issue_inc = (issue_idx_r == SLOT_W'(SLOTS - 1)) ? '0 : issue_idx_r + 1'b1;
  assign rd_en     = issue;
  assign rd_addr   = issue_idx_r;
  assign in_tready = !walking_r;

  always_comb begin
    walking_nxt   = walking_r;
    issue_idx_nxt = issue_idx_r;
    issue_cnt_nxt = issue_cnt_r;
    pend_nxt      = pend_r;
    pend_last_nxt = pend_last_r;
    pend_vld_nxt  = pend_vld_r;
    pend_idx_nxt  = pend_idx_r;
    before_nxt    = before_r;
    offset_nxt    = offset_r;
    if (find_xfer) begin
      walking_nxt   = 1'b1;
      issue_idx_nxt = rslot_r;
      issue_cnt_nxt = '0;
      pend_nxt      = 1'b0;
      before_nxt    = '0;
      offset_nxt    = in_offset;
    end else if (walking_r && !stall) begin
      if (done) begin
        walking_nxt = 1'b0;
        pend_nxt    = 1'b0;
      end else begin
        // Zero-handle entries do not advance the running total
        if (pend_r && (ent_handle != '0)) begin
          before_nxt = ent_end;
        end
        pend_nxt = issue;
        if (issue) begin
          pend_idx_nxt  = issue_idx_r;
          pend_vld_nxt  = vld_r[issue_idx_r];
          pend_last_nxt = (issue_cnt_r == CNT_W'(SLOTS - 1));
          issue_idx_nxt = issue_inc;
          issue_cnt_nxt = issue_cnt_r + 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic                  found_r, found_nxt;
  logic [SLOT_IDX_W-1:0] slot_r, slot_nxt;
  logic [HANDLE_W-1:0]   fhandle_r, fhandle_nxt;
  logic [BYTE_OFS_W-1:0] bofs_r, bofs_nxt;

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    found_nxt      = found_r;
    slot_nxt       = slot_r;
    fhandle_nxt    = fhandle_r;
    bofs_nxt       = bofs_r;
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
    if (walking_r && done && !stall) begin
      out_tvalid_nxt = 1'b1;
      found_nxt      = hit;
      slot_nxt       = hit ? SLOT_IDX_W'(pend_idx_r) : '0;
      fhandle_nxt    = hit ? HANDLE_W'(ent_handle) : '0;
      bofs_nxt       = hit ? BYTE_OFS_W'(ofs_rel) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wslot_r      <= '0;
      rslot_r      <= '0;
      full_r       <= 1'b0;
      vld_r        <= '0;
      walking_r    <= 1'b0;
      pend_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      wslot_r      <= wslot_nxt;
      rslot_r      <= rslot_nxt;
      full_r       <= full_nxt;
      vld_r        <= vld_nxt;
      walking_r    <= walking_nxt;
      pend_r       <= pend_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    issue_idx_r <= issue_idx_nxt;
    issue_cnt_r <= issue_cnt_nxt;
    pend_last_r <= pend_last_nxt;
    pend_vld_r  <= pend_vld_nxt;
    pend_idx_r  <= pend_idx_nxt;
    before_r    <= before_nxt;
    offset_r    <= offset_nxt;
    found_r     <= found_nxt;
    slot_r      <= slot_nxt;
    fhandle_r   <= fhandle_nxt;
    bofs_r      <= bofs_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = found_r;
  assign out_tdata  = {(OUT_TDATA_W - SLOT_IDX_W - HANDLE_W - BYTE_OFS_W)'(0),
                       bofs_r, fhandle_r, slot_r};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_full_ptrs_equal : assert property (@(posedge clk) disable iff (!rst_n)
    full_r |-> (rslot_r == wslot_r))
    else $error("full ring with read slot apart from write slot");

  a_not_full_rslot_zero : assert property (@(posedge clk) disable iff (!rst_n)
    !full_r |-> (rslot_r == '0))
    else $error("read slot moved before ring filled");

  a_pend_in_walk : assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> walking_r)
    else $error("pending entry outside a walk");

  a_walk_bounded : assert property (@(posedge clk) disable iff (!rst_n)
    walking_r |-> (issue_cnt_r <= CNT_W'(SLOTS)))
    else $error("walk issued more reads than slots");

  a_done_ends_walk : assert property (@(posedge clk) disable iff (!rst_n)
    (walking_r && done && !stall) |=> (!walking_r && out_tvalid_r))
    else $error("finished walk did not load a result");

endmodule

/* verif/tb_ring_of_writes_with_offset_lookup.sv */
`timescale 1ns / 1ps
// Self-checking testbench for ring_of_writes_with_offset_lookup: adds and finds
// on the stream ports, predicted by a local ring model, with random pacing.
// Depends on rowol_pkg and the block itself.
module tb_ring_of_writes_with_offset_lookup;
  import rowol_pkg::*;

  localparam int SLOTS         = DEF_SLOTS;
  localparam int QUIET_LIMIT   = 1000;           // cycles with no transfer at all
  localparam int SETTLE_CYCLES = 2 * DEF_SLOTS + 4;

  typedef enum int {SND_STREAM, SND_BURSTS, SND_SPARSE} send_pace_t;
  typedef enum int {RCV_ALWAYS, RCV_RANDOM, RCV_LONG_STALLS} recv_pace_t;

  typedef struct packed {
    logic                  found;
    logic [SLOT_IDX_W-1:0] slot;
    logic [HANDLE_W-1:0]   handle;
    logic [BYTE_OFS_W-1:0] byte_ofs;
  } lookup_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [MODE_W-1:0]      in_tuser   = MODE_ADD;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;

  // Local copy of the ring contents and pointers
  logic [HANDLE_W-1:0] ring_handle [SLOTS];
  logic [SIZE_W-1:0]   ring_len    [SLOTS];
  int                  ring_wr;
  int                  ring_rd;
  bit                  ring_full;

  lookup_t    lookups_due[$];
  lookup_t    want;
  int         errors      = 0;
  int         quiet_count = 0;
  int         burst_left  = 0;
  int         stall_left  = 0;
  send_pace_t snd_pace    = SND_STREAM;
  recv_pace_t rcv_pace    = RCV_ALWAYS;

  ring_of_writes_with_offset_lookup i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #1 clk = ~clk;

  function automatic int next_slot(input int s);
    return (s + 1 >= SLOTS) ? 0 : s + 1;
  endfunction

  // Write one entry at the write slot; once full, drag the read slot along.
  task automatic store_entry(input logic [HANDLE_W-1:0] handle, input logic [SIZE_W-1:0] len);
    ring_handle[ring_wr] = handle;
    ring_len[ring_wr]    = len;
    ring_wr              = next_slot(ring_wr);
    if (ring_wr == ring_rd || ring_full) begin
      ring_full = 1'b1;
      ring_rd   = ring_wr;
    end
  endtask

  // Walk every slot from the oldest; zero-handle entries can match but do not
  // advance the running start.
  function automatic lookup_t lookup_offset(input logic [OFFSET_W-1:0] ofs);
    lookup_t         r;
    longint unsigned start;
    longint unsigned stop;
    int              s;
    int              k;
    r     = '0;
    start = 0;
    s     = ring_rd;
    for (k = 0; k < SLOTS; k++) begin
      stop = start + ring_len[s];
      if (!r.found && ofs < stop && ofs >= start) begin
        r.found    = 1'b1;
        r.slot     = SLOT_IDX_W'(s);
        r.handle   = ring_handle[s];
        r.byte_ofs = BYTE_OFS_W'(ofs - start);
      end
      if (ring_handle[s] != '0) start = stop;
      s = next_slot(s);
    end
    return r;
  endfunction

  // Running start after walking the given number of slots from the oldest.
  function automatic longint unsigned walk_start(input int steps);
    longint unsigned start;
    int              s;
    int              k;
    start = 0;
    s     = ring_rd;
    for (k = 0; k < steps; k++) begin
      if (ring_handle[s] != '0) start += ring_len[s];
      s = next_slot(s);
    end
    return start;
  endfunction

  // Offer one item, hold it until the transfer, predict, then apply sender pacing.
  task automatic send_item(input logic [MODE_W-1:0] kind, input logic [HANDLE_W-1:0] handle,
                           input logic [SIZE_W-1:0] len, input logic [OFFSET_W-1:0] ofs);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {4'b0, ofs, len, handle};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (kind == MODE_ADD) store_entry(handle, len);
    else lookups_due.push_back(lookup_offset(ofs));
    case (snd_pace)
      SND_STREAM: ;
      SND_BURSTS: begin
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          in_tvalid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk);
          burst_left = $urandom_range(0, 7);
        end
      end
      default: begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    endcase
  endtask

  // Drop valid, then hold until every find has answered.
  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (lookups_due.size() != 0) @(posedge clk);
  endtask

  // Check each result transfer against the oldest prediction; pace the receiver.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (lookups_due.size() == 0) begin
        $error("result transfer with no find pending");
        errors++;
      end else begin
        want = lookups_due.pop_front();
        if (out_tuser !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, out_tuser);
          errors++;
        end
        if (out_tdata[0 +: SLOT_IDX_W] !== want.slot) begin
          $error("slot_index: expected %0d, got %0d", want.slot, out_tdata[0 +: SLOT_IDX_W]);
          errors++;
        end
        if (out_tdata[SLOT_IDX_W +: HANDLE_W] !== want.handle) begin
          $error("found_handle: expected %h, got %h", want.handle,
                 out_tdata[SLOT_IDX_W +: HANDLE_W]);
          errors++;
        end
        if (out_tdata[SLOT_IDX_W + HANDLE_W +: BYTE_OFS_W] !== want.byte_ofs) begin
          $error("byte_offset: expected %0d, got %0d", want.byte_ofs,
                 out_tdata[SLOT_IDX_W + HANDLE_W +: BYTE_OFS_W]);
          errors++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      case (rcv_pace)
        RCV_ALWAYS: out_tready <= 1'b1;
        RCV_RANDOM: out_tready <= ($urandom_range(0, 99) < 60);
        default: begin
          if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 15);
            out_tready <= 1'b0;
          end else begin
            out_tready <= 1'b1;
          end
        end
      endcase
    end
  end

  // Stop a hung run: count cycles in which neither channel transfers.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_count <= 0;
    else quiet_count <= quiet_count + 1;
    if (quiet_count >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Finds on a freshly reset ring: every slot empty, nothing matches.
  task automatic test_empty_ring();
    send_item(MODE_FIND, '1, '1, '0);
    send_item(MODE_FIND, '0, '0, '1);
  endtask

  // Largest entry, empty entry, zero-handle overlap, and offsets on each edge.
  task automatic test_extremes_and_zero_handle();
    snd_pace = SND_BURSTS;
    rcv_pace = RCV_RANDOM;
    send_item(MODE_ADD, 32'hFFFF_FFFF, 16'hFFFF, '1);
    send_item(MODE_ADD, 32'h0000_0001, 16'h0000, '0);
    send_item(MODE_ADD, 32'h0000_0000, 16'h0005, '0);
    send_item(MODE_ADD, 32'h0000_0007, 16'h0003, '0);
    send_item(MODE_FIND, '0, '0, 20'd0);
    send_item(MODE_FIND, '0, '0, 20'd65534);
    send_item(MODE_FIND, '1, '1, 20'd65535);
    send_item(MODE_FIND, '0, '0, 20'd65539);
    send_item(MODE_FIND, '0, '0, 20'd65540);
    send_item(MODE_FIND, '0, '0, 20'hFFFFF);
  endtask

  // Run past the ring size so the oldest entries are overwritten.
  task automatic test_wrap_overwrite();
    int i;
    snd_pace = SND_STREAM;
    rcv_pace = RCV_LONG_STALLS;
    for (i = 0; i < SLOTS + 1; i++) send_item(MODE_ADD, 32'h100 + i, 16'd2, '0);
    send_item(MODE_FIND, '0, '0, 20'd0);
    send_item(MODE_FIND, '0, '0, 20'd19);
  endtask

  // Mostly small entries and offsets aimed at the stored span; some noise.
  task automatic test_random_traffic(input int count);
    int                  i;
    int                  pick;
    longint unsigned     target;
    logic [HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0]   len;
    logic [OFFSET_W-1:0] ofs;
    for (i = 0; i < count; i++) begin
      if (i % 80 == 0) begin
        snd_pace = send_pace_t'($urandom_range(0, 2));
        rcv_pace = recv_pace_t'($urandom_range(0, 2));
      end
      pick   = $urandom_range(0, 7);
      handle = (pick == 0) ? '0 : (pick == 1) ? '1 : HANDLE_W'($urandom);
      pick   = $urandom_range(0, 19);
      case (pick)
        0:       len = '0;
        1:       len = '1;
        2, 3:    len = SIZE_W'($urandom);
        4, 5, 6: len = SIZE_W'($urandom_range(16, 255));
        default: len = SIZE_W'($urandom_range(1, 15));
      endcase
      ofs = OFFSET_W'($urandom_range(0, 20'hFFFFF));
      if ($urandom_range(0, 99) < 50) begin
        send_item(MODE_ADD, handle, len, ofs);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          target = $urandom_range(0, int'(walk_start(SLOTS)));
        end else if (pick < 85) begin
          // land on, just before or just after an entry boundary
          target = walk_start($urandom_range(0, SLOTS)) + $urandom_range(0, 2);
          target = (target > 0) ? target - 1 : 0;
        end else begin
          target = ofs;
        end
        send_item(MODE_FIND, handle, len, target[OFFSET_W-1:0]);
      end
    end
  endtask

  // Hold the sender until every pending find has answered, then resume.
  task automatic test_pause_for_results();
    wait_results_drained();
    test_random_traffic(20);
  endtask

  initial begin
    ring_wr   = 0;
    ring_rd   = 0;
    ring_full = 1'b0;
    for (int s = 0; s < SLOTS; s++) begin
      ring_handle[s] = '0;
      ring_len[s]    = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_ring();
    test_extremes_and_zero_handle();
    test_wrap_overwrite();
    test_random_traffic(600);
    test_pause_for_results();
    test_random_traffic(605);
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
